/* rtl/core/lkvc_pkg.sv */
// Shared types, codes and constants of the LRU key-value cache.
`timescale 1ns / 1ps
package lkvc_pkg;

    localparam int FUNC_W   = 1;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 4;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 4'd5;

    localparam logic [FUNC_W-1:0] FUNC_GET = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_PUT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic capture;
        logic match;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/core/lkvc_if.sv */
// Handshake channel interfaces for requests, responses and configuration.
`timescale 1ns / 1ps
interface lkvc_req_if;
    import lkvc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic signed [KEY_W-1:0]   lookup_key;
    logic [VALUE_W-1:0]        entry_value;
    modport source (output valid, output func, output lookup_key, output entry_value,
                     input ready);
    modport sink (input valid, input func, input lookup_key, input entry_value,
                   output ready);
endinterface

interface lkvc_rsp_if;
    import lkvc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [VALUE_W-1:0]    read_value;
    modport source (output valid, output status, output read_value, input ready);
    modport sink (input valid, input status, input read_value, output ready);
endinterface

interface lkvc_cfg_if;
    import lkvc_pkg::*;
    logic               valid;
    logic               ready;
    logic [CAP_W-1:0]   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/lru_key_value_cache_unit.sv */
// Top level of the LRU key-value cache: controller, datapath and channel wiring.
//
// Channel   Direction  Transfer content
// i_req     in         func, lookup_key, entry_value
// o_rsp     out        status, read_value
// i_cfg     in         capacity_in_use (4 bits)
//
// An item passes through accept, key compare and update before its result is loaded.
// The recency update of one item must finish before the next compare, so at most one item
// is in flight and a new request is not accepted until the previous item's update is done.
// A new request is accepted while the previous result still waits in the output register.
// When the output register stays full, the update step stalls until it is taken.
// Reset clears all valid bits, ranks and occupancy at once and loads a capacity of five.
`timescale 1ns / 1ps
module lru_key_value_cache_unit #(
    parameter int ENTRIES    = 8,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lkvc_req_if.sink   i_req,
    lkvc_rsp_if.source o_rsp,
    lkvc_cfg_if.sink   i_cfg
);
    import lkvc_pkg::*;

    t_cmd     w_cmd;
    t_dp_stat w_stat;
    logic     w_req_ready;

    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    lkvc_datapath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_func        (i_req.func),
        .i_lookup_key  (i_req.lookup_key),
        .i_entry_value (i_req.entry_value),
        .i_cfg_write   (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .o_out_valid   (o_rsp.valid),
        .i_out_ready   (o_rsp.ready),
        .o_status      (o_rsp.status),
        .o_read_value  (o_rsp.read_value)
    );

    assign i_req.ready = w_req_ready;
    assign i_cfg.ready = 1'b1;

endmodule

/* rtl/core/lkvc_ctrl.sv */
// Controller state machine that sequences accept, compare and update.
`timescale 1ns / 1ps
module lkvc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  lkvc_pkg::t_dp_stat i_stat,
    output lkvc_pkg::t_cmd    o_cmd
);
    import lkvc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.capture = i_req_valid;
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
            end
            S_UPDATE: begin
                o_cmd.update = i_stat.out_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/lkvc_datapath.sv */
// Datapath with entry storage, parallel key compare, recency ranks and result register.
`timescale 1ns / 1ps
module lkvc_datapath #(
    parameter int ENTRIES    = 8,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lkvc_pkg::t_cmd                  i_cmd,
    output lkvc_pkg::t_dp_stat              o_stat,
    input  logic [lkvc_pkg::FUNC_W-1:0]     i_func,
    input  logic signed [lkvc_pkg::KEY_W-1:0] i_lookup_key,
    input  logic [lkvc_pkg::VALUE_W-1:0]    i_entry_value,
    input  logic                            i_cfg_write,
    input  logic [lkvc_pkg::CAP_W-1:0]      i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [lkvc_pkg::STATUS_W-1:0]   o_status,
    output logic [lkvc_pkg::VALUE_W-1:0]    o_read_value
);
    import lkvc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    logic [KEY_BITS-1:0]   r_keys [ENTRIES];
    logic [VALUE_BITS-1:0] r_vals [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;
    logic [IDX_W-1:0]      r_rank [ENTRIES];
    logic [OCC_W-1:0]      r_occ;
    logic [CAP_W-1:0]      r_cap;

    logic [FUNC_W-1:0]     r_func;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;

    logic                  r_hit;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [IDX_W-1:0]      r_hit_rank;
    logic [ENTRIES-1:0]    r_evict_vec;
    logic                  r_evict;
    logic [IDX_W-1:0]      r_slot;

    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [VALUE_W-1:0]    r_out_value;

    logic                  n_hit;
    logic [IDX_W-1:0]      n_hit_idx;
    logic [ENTRIES-1:0]    n_evict_vec;
    logic                  n_evict;
    logic [IDX_W-1:0]      n_slot;
    logic [CMP_W-1:0]      eff_cap;
    logic [CMP_W-1:0]      cap_ext;
    logic [ENTRIES-1:0]    kept_vec;
    logic                  slot_found;

    logic [ENTRIES-1:0]    n_valid;
    logic [IDX_W-1:0]      n_rank [ENTRIES];
    logic [OCC_W-1:0]      n_occ;
    logic [STATUS_W-1:0]   n_out_status;
    logic [VALUE_W-1:0]    n_out_value;
    logic                  put_new;

    // Compare stage: match, victim and free slot from the captured request.
    always_comb begin
        n_hit     = 1'b0;
        n_hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!n_hit && r_valid[i] && (r_keys[i] == r_key)) begin
                n_hit     = 1'b1;
                n_hit_idx = IDX_W'(i);
            end
        end
        cap_ext = CMP_W'(r_cap);
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
        n_evict = (CMP_W'(r_occ) >= eff_cap);
        for (int i = 0; i < ENTRIES; i++) begin
            n_evict_vec[i] = n_evict && r_valid[i]
                             && (OCC_W'(r_rank[i]) == (r_occ - OCC_W'(1)));
        end
        kept_vec   = r_valid & ~n_evict_vec;
        slot_found = 1'b0;
        n_slot     = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!slot_found && !kept_vec[i]) begin
                slot_found = 1'b1;
                n_slot     = IDX_W'(i);
            end
        end
    end

    // Update stage: next recency order, occupancy and result.
    always_comb begin
        put_new      = (r_func == FUNC_PUT) && !r_hit;
        n_valid      = r_valid;
        n_occ        = r_occ;
        n_out_status = ST_OK;
        n_out_value  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
        end
        if (r_func == FUNC_GET) begin
            if (r_hit) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && (r_rank[i] < r_hit_rank)) begin
                        n_rank[i] = r_rank[i] + IDX_W'(1);
                    end
                end
                n_rank[r_hit_idx] = '0;
                n_out_value       = VALUE_W'(r_vals[r_hit_idx]);
            end else begin
                n_out_status = ST_MISS;
            end
        end else if (r_hit) begin
            n_out_status = ST_DUP;
        end else begin
            n_valid = r_valid & ~r_evict_vec;
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_evict_vec[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i]) begin
                    n_rank[i] = r_rank[i] + IDX_W'(1);
                end
            end
            n_valid[r_slot] = 1'b1;
            n_rank[r_slot]  = '0;
            n_occ           = r_occ - OCC_W'(r_evict) + OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_occ       <= '0;
            r_cap       <= CAPACITY_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_write) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.update) begin
                r_valid     <= n_valid;
                r_occ       <= n_occ;
                r_rank      <= n_rank;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_key  <= KEY_BITS'(i_lookup_key);
            r_val  <= VALUE_BITS'(i_entry_value);
        end
        if (i_cmd.match) begin
            r_hit       <= n_hit;
            r_hit_idx   <= n_hit_idx;
            r_hit_rank  <= r_rank[n_hit_idx];
            r_evict_vec <= n_evict_vec;
            r_evict     <= n_evict;
            r_slot      <= n_slot;
        end
        if (i_cmd.update) begin
            r_out_status <= n_out_status;
            r_out_value  <= n_out_value;
            if (put_new) begin
                r_keys[r_slot] <= r_key;
                r_vals[r_slot] <= r_val;
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_read_value    = r_out_value;

endmodule

/* rtl/core/lkvc_checker.sv */
// Port-level assertions for the LRU key-value cache and their binding to the top level.
`timescale 1ns / 1ps
module lkvc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [lkvc_pkg::STATUS_W-1:0] i_rsp_status,
    input logic [lkvc_pkg::VALUE_W-1:0]  i_rsp_value
);
    import lkvc_pkg::*;

    logic w_in_xfer;
    assign w_in_xfer = i_req_valid && i_req_ready;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !i_req_ready)
        else $error("request accepted while an item was still in flight");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(w_in_xfer, 3))
        else $error("result appeared without a request three cycles earlier");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status == ST_OK || i_rsp_status == ST_MISS
                         || i_rsp_status == ST_DUP))
        else $error("undefined status code");

    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != ST_OK) |-> (i_rsp_value == '0))
        else $error("nonzero value with a miss or refused put");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_value)))
        else $error("stalled result changed");

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_value  (o_rsp.read_value)
);
